// ===== design/assert_macros.svh =====
// assertion helpers used by the checker file mpe_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/mpe_pkg.sv =====
package mpe_pkg;

    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;
    localparam int SCALE_W   = 20;
    localparam int COUNT_W   = 8;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;

    // pixel index is stretched to a 1024 wide span before centring
    localparam int SPAN_SHIFT  = 10;
    localparam int OFFSET_MID  = 1 << 9;
    // reciprocal scaling for the divide by the frame size
    localparam int RECIP_SHIFT = 32;

    localparam logic signed [DATA_W-1:0] CENTER_REAL_RST = -32'sd247586821;
    localparam logic signed [DATA_W-1:0] CENTER_IMAG_RST = 32'sd83284740;
    localparam logic [COUNT_W-1:0]       ITER_LIMIT_RST  = 8'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_REAL = 2'd0,
        REG_CENTER_IMAG = 2'd1,
        REG_ITER_LIMIT  = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_Q,
        ST_DIV_R,
        ST_DIV_FIX,
        ST_SCALE,
        ST_ADD,
        ST_XX,
        ST_YY,
        ST_XY,
        ST_UPD,
        ST_DONE
    } t_state;

endpackage

// ===== design/mpe_in_if.sv =====
interface mpe_in_if;
    logic                        valid;
    logic                        ready;
    logic [mpe_pkg::COL_W-1:0]   column;
    logic [mpe_pkg::ROW_W-1:0]   row;
    logic [mpe_pkg::SCALE_W-1:0] width_scale;
    logic [mpe_pkg::SCALE_W-1:0] height_scale;

    modport source (output valid, column, row, width_scale, height_scale, input ready);
    modport sink   (input valid, column, row, width_scale, height_scale, output ready);
endinterface

// ===== design/mpe_out_if.sv =====
interface mpe_out_if;
    logic                        valid;
    logic                        ready;
    logic                        pixel_color;
    logic [mpe_pkg::COUNT_W-1:0] inside_count;

    modport source (output valid, pixel_color, inside_count, input ready);
    modport sink   (input valid, pixel_color, inside_count, output ready);
endinterface

// ===== design/mandelbrot_pixel_escape.sv =====
// Fixed-point Mandelbrot escape count for one pixel at a time.
// i_pix carries column, row and the frame's two scale values; a transfer
// happens when valid and ready are both high. o_pix returns pixel_color and
// inside_count, one result for each pixel taken. Centre and iteration limit
// are written through the plain cfg port (index 0 centre real, 1 centre
// imaginary, 2 iteration limit); the user must write them only while no
// pixel is in flight, as the block itself does not enforce this.
// A single 32x32 signed multiplier with a registered product does all the
// multiplications under a small sequencer: per axis it forms c (divide by
// the frame size via reciprocal, correct, scale, add), then per iteration
// it forms x*x, y*y, x*y and the update, then it loads the result.
// i_pix.ready is high only while the sequencer is idle, so a new pixel is
// taken only after the result of the last one has been loaded.
// The result sits in an output register, so the next pixel is taken and
// worked on while a stalled result waits; a finished pixel then holds in
// its last state until the output register is free.
// Reset (synchronous, active low) returns the sequencer to idle, drops
// o_pix.valid and restores the default centre and limit of 50.
module mandelbrot_pixel_escape #(
    parameter int IMAGE_WIDTH   = 1024,
    parameter int IMAGE_HEIGHT  = 768,
    parameter int FRACTION_BITS = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mpe_pkg::DATA_W-1:0]    i_cfg_data,
    mpe_in_if.sink                        i_pix,
    mpe_out_if.source                     o_pix
);

    localparam int NUM_W = mpe_pkg::COL_W + mpe_pkg::SPAN_SHIFT;
    localparam int SQ_W  = 64 - FRACTION_BITS;
    localparam int CW    = mpe_pkg::COUNT_W;
    localparam int DW    = mpe_pkg::DATA_W;

    localparam logic [DW-1:0] RECIP_W =
        DW'((64'd1 << mpe_pkg::RECIP_SHIFT) / IMAGE_WIDTH);
    localparam logic [DW-1:0] RECIP_H =
        DW'((64'd1 << mpe_pkg::RECIP_SHIFT) / IMAGE_HEIGHT);
    localparam logic [NUM_W-1:0] DIV_W   = NUM_W'(IMAGE_WIDTH);
    localparam logic [NUM_W-1:0] DIV_H   = NUM_W'(IMAGE_HEIGHT);
    localparam logic [SQ_W:0]    FOUR_FX = (SQ_W+1)'(64'd4 << FRACTION_BITS);

    mpe_pkg::t_state r_state, n_state;

    logic signed [DW-1:0] r_center_real, r_center_imag;
    logic [CW-1:0]        r_limit;

    logic [mpe_pkg::COL_W-1:0]   r_column, n_column;
    logic [mpe_pkg::ROW_W-1:0]   r_row, n_row;
    logic [mpe_pkg::SCALE_W-1:0] r_wscale, n_wscale, r_hscale, n_hscale;
    logic                        r_axis, n_axis;
    logic [NUM_W-1:0]            r_quot, n_quot;
    logic signed [NUM_W:0]       r_offset, n_offset;
    logic signed [DW-1:0]        r_cre, n_cre, r_cim, n_cim;
    logic [DW-1:0]               r_x, n_x, r_y, n_y;
    logic [SQ_W-1:0]             r_xx, n_xx, r_yy, n_yy;
    logic [CW-1:0]               r_iter, n_iter, r_count, n_count;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_color, n_out_color;
    logic [CW-1:0]               r_out_count, n_out_count;
    logic signed [63:0]          r_prod;

    // shared multiplier
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [63:0]   mul_p;
    assign mul_p = mul_a * mul_b;

    // per-axis operand selection
    logic [NUM_W-1:0]            cur_num, cur_div, q0, rem, q_fix;
    logic [DW-1:0]               cur_recip;
    logic [mpe_pkg::SCALE_W-1:0] cur_scale;
    logic signed [DW-1:0]        cur_center, c_val;
    logic [SQ_W:0]               mag;
    logic                        last_iter;

    assign cur_num    = r_axis ? {r_row, {mpe_pkg::SPAN_SHIFT{1'b0}}}
                               : {r_column, {mpe_pkg::SPAN_SHIFT{1'b0}}};
    assign cur_recip  = r_axis ? RECIP_H : RECIP_W;
    assign cur_div    = r_axis ? DIV_H : DIV_W;
    assign cur_scale  = r_axis ? r_hscale : r_wscale;
    assign cur_center = r_axis ? r_center_imag : r_center_real;

    assign q0    = r_prod[mpe_pkg::RECIP_SHIFT +: NUM_W];
    assign rem   = cur_num - r_prod[NUM_W-1:0];
    assign q_fix = (rem >= cur_div) ? r_quot + NUM_W'(1) : r_quot;
    assign c_val = cur_center + signed'(r_prod[DW-1:0]);
    assign mag   = {1'b0, r_xx} + {1'b0, r_yy};
    assign last_iter = ({1'b0, r_iter} + (CW+1)'(1)) == {1'b0, r_limit};

    assign i_pix.ready        = (r_state == mpe_pkg::ST_IDLE);
    assign o_pix.valid        = r_out_valid;
    assign o_pix.pixel_color  = r_out_color;
    assign o_pix.inside_count = r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_real <= mpe_pkg::CENTER_REAL_RST;
            r_center_imag <= mpe_pkg::CENTER_IMAG_RST;
            r_limit       <= mpe_pkg::ITER_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (mpe_pkg::t_cfg_reg'(i_cfg_index))
                mpe_pkg::REG_CENTER_REAL: r_center_real <= signed'(i_cfg_data);
                mpe_pkg::REG_CENTER_IMAG: r_center_imag <= signed'(i_cfg_data);
                mpe_pkg::REG_ITER_LIMIT:  r_limit       <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis      <= 1'b0;
            r_iter      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_axis      <= n_axis;
            r_iter      <= n_iter;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_column    <= n_column;
        r_row       <= n_row;
        r_wscale    <= n_wscale;
        r_hscale    <= n_hscale;
        r_quot      <= n_quot;
        r_offset    <= n_offset;
        r_cre       <= n_cre;
        r_cim       <= n_cim;
        r_x         <= n_x;
        r_y         <= n_y;
        r_xx        <= n_xx;
        r_yy        <= n_yy;
        r_out_color <= n_out_color;
        r_out_count <= n_out_count;
        r_prod      <= mul_p;
    end

    always_comb begin
        n_state     = r_state;
        n_column    = r_column;
        n_row       = r_row;
        n_wscale    = r_wscale;
        n_hscale    = r_hscale;
        n_axis      = r_axis;
        n_quot      = r_quot;
        n_offset    = r_offset;
        n_cre       = r_cre;
        n_cim       = r_cim;
        n_x         = r_x;
        n_y         = r_y;
        n_xx        = r_xx;
        n_yy        = r_yy;
        n_iter      = r_iter;
        n_count     = r_count;
        n_out_valid = r_out_valid & ~o_pix.ready;
        n_out_color = r_out_color;
        n_out_count = r_out_count;
        mul_a       = '0;
        mul_b       = '0;

        unique case (r_state)
            mpe_pkg::ST_IDLE: begin
                if (i_pix.valid) begin
                    n_column = i_pix.column;
                    n_row    = i_pix.row;
                    n_wscale = i_pix.width_scale;
                    n_hscale = i_pix.height_scale;
                    n_axis   = 1'b0;
                    n_state  = mpe_pkg::ST_DIV_Q;
                end
            end
            mpe_pkg::ST_DIV_Q: begin
                // quotient estimate, at most one short
                mul_a   = signed'(DW'(cur_num));
                mul_b   = signed'(cur_recip);
                n_state = mpe_pkg::ST_DIV_R;
            end
            mpe_pkg::ST_DIV_R: begin
                n_quot  = q0;
                mul_a   = signed'(DW'(q0));
                mul_b   = signed'(DW'(cur_div));
                n_state = mpe_pkg::ST_DIV_FIX;
            end
            mpe_pkg::ST_DIV_FIX: begin
                n_offset = signed'({1'b0, q_fix}) - (NUM_W+1)'(mpe_pkg::OFFSET_MID);
                n_state  = mpe_pkg::ST_SCALE;
            end
            mpe_pkg::ST_SCALE: begin
                mul_a   = DW'(r_offset);
                mul_b   = signed'(DW'(cur_scale));
                n_state = mpe_pkg::ST_ADD;
            end
            mpe_pkg::ST_ADD: begin
                if (!r_axis) begin
                    n_cre   = c_val;
                    n_axis  = 1'b1;
                    n_state = mpe_pkg::ST_DIV_Q;
                end else begin
                    n_cim   = c_val;
                    n_x     = '0;
                    n_y     = '0;
                    n_iter  = '0;
                    n_count = '0;
                    n_state = (r_limit == '0) ? mpe_pkg::ST_DONE : mpe_pkg::ST_XX;
                end
            end
            mpe_pkg::ST_XX: begin
                mul_a   = signed'(r_x);
                mul_b   = signed'(r_x);
                n_state = mpe_pkg::ST_YY;
            end
            mpe_pkg::ST_YY: begin
                // squares are never negative
                n_xx    = r_prod[63:FRACTION_BITS];
                mul_a   = signed'(r_y);
                mul_b   = signed'(r_y);
                n_state = mpe_pkg::ST_XY;
            end
            mpe_pkg::ST_XY: begin
                n_yy    = r_prod[63:FRACTION_BITS];
                mul_a   = signed'(r_x);
                mul_b   = signed'(r_y);
                n_state = mpe_pkg::ST_UPD;
            end
            mpe_pkg::ST_UPD: begin
                n_x = r_xx[DW-1:0] - r_yy[DW-1:0] + r_cre;
                // low bits of twice the shifted cross product
                n_y = {r_prod[FRACTION_BITS +: DW-1], 1'b0} + r_cim;
                if (mag <= FOUR_FX) begin
                    n_count = r_count + CW'(1);
                end
                n_iter  = r_iter + CW'(1);
                n_state = last_iter ? mpe_pkg::ST_DONE : mpe_pkg::ST_XX;
            end
            mpe_pkg::ST_DONE: begin
                if (!r_out_valid || o_pix.ready) begin
                    n_out_valid = 1'b1;
                    n_out_color = (r_count >= r_limit) ? 1'b0 : 1'b1;
                    n_out_count = r_count;
                    n_state     = mpe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mpe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/mpe_checker.sv =====
`include "assert_macros.svh"

module mpe_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_color,
    input logic [mpe_pkg::COUNT_W-1:0] i_out_count
);

    // one pixel at a time: busy right after a transfer in
    `ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // a white pixel fell short of the limit, which never exceeds the count range
    `ASSERT_SAME(a_white_short, i_out_valid && i_out_color,
                 i_out_count != {mpe_pkg::COUNT_W{1'b1}})

    `ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    `ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready,
                 $stable(i_out_color) && $stable(i_out_count))

endmodule

bind mandelbrot_pixel_escape mpe_checker u_mpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_color (o_pix.pixel_color),
    .i_out_count (o_pix.inside_count)
);
